// ----- rtl/salc_pkg.sv -----
package salc_pkg;

  // Configuration register widths, fixed by the register map.
  localparam int unsigned SET_BITS_W   = 4;
  localparam int unsigned BLOCK_BITS_W = 5;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 5;

  // Running totals wrap at this width.
  localparam int unsigned TOTAL_W = 32;

  // Width of the address field on the input channel.
  localparam int unsigned ADDR_PORT_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_index_e;

  // Outcome of one lookup, passed from the set update logic to the core.
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

endpackage

// ----- rtl/set_assoc_lru_cache_model_core.sv -----
// Set-associative cache model with true LRU replacement.
// Input channel: one byte address per transaction (in_valid_i, in_stall_o).
// The address is split into block offset, set index and tag according to the
// set_bits and block_bits registers, and the selected set is looked up.
// Output channel: one result per input transaction (out_valid_o, out_stall_i)
// carrying the hit and eviction flags and the running hit, miss and eviction
// totals, which wrap at 32 bits.
// Configuration: cfg_valid_i/cfg_ready_o write channel with a register index
// and data; cfg_ready_o is always high. Registers are to be written only
// while idle; the block does not enforce this. A transaction passes through
// the lookup stage, which reads its set row, and then the output register,
// taking one transaction per cycle while the output is not stalled, bounded by
// the single read and write port of the set memory. Back-to-back accesses to
// the same set are served by forwarding the written-back row. Reset: clears
// the counters, set_bits and block_bits, sets ways to 1, then sweeps the set
// memory, marking every set empty one set per cycle with in_stall_o held high.
// When the receiver stalls, the result holds on the output; one further
// transaction may be taken in and waits in the lookup stage until the
// output frees up.
module set_assoc_lru_cache_model_core #(
  parameter int unsigned MAX_SET_BITS  = 8,
  parameter int unsigned MAX_WAYS      = 8,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [salc_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [salc_pkg::ADDR_PORT_W-1:0]    address_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                was_hit_o,
  output logic                                was_evict_o,
  output logic [salc_pkg::TOTAL_W-1:0]        hit_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]        miss_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]        evict_total_o
);

  localparam int unsigned SETS    = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned FILL_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned TAGS_W  = MAX_WAYS * ADDRESS_WIDTH;
  localparam int unsigned RANKS_W = MAX_WAYS * RANK_W;
  localparam int unsigned ROW_W   = FILL_W + RANKS_W + TAGS_W;
  localparam int unsigned SHIFT_W = salc_pkg::BLOCK_BITS_W + 1;

  // Configuration registers.
  logic [salc_pkg::SET_BITS_W-1:0]   set_bits_q;
  logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_q;
  logic [salc_pkg::WAYS_W-1:0]       ways_q;

  // Reset sweep over the set memory.
  logic             clr_q;
  logic [SET_W-1:0] clr_addr_q;

  // Lookup stage: the set row is being read for this transaction.
  logic                     s1_q;
  logic [SET_W-1:0]         s1_set_q;
  logic [ADDRESS_WIDTH-1:0] s1_tag_q;
  logic                     fwd_q;
  logic [ROW_W-1:0]         fwd_row_q;

  // Output register and running totals.
  logic                         out_valid_q;
  logic                         hit_q;
  logic                         evict_q;
  logic [salc_pkg::TOTAL_W-1:0] hit_cnt_q;
  logic [salc_pkg::TOTAL_W-1:0] miss_cnt_q;
  logic [salc_pkg::TOTAL_W-1:0] evict_cnt_q;

  logic [ADDRESS_WIDTH-1:0]    addr;
  logic [ADDRESS_WIDTH-1:0]    addr_shr;
  logic [salc_pkg::SET_BITS_W-1:0] sb;
  logic [SHIFT_W-1:0]          tag_shift;
  logic [SET_W-1:0]            set_mask;
  logic [SET_W-1:0]            set_idx;
  logic [ADDRESS_WIDTH-1:0]    tag;
  logic [FILL_W-1:0]           ways_eff;

  logic                        accept;
  logic                        out_free;
  logic                        s1_done;

  logic                        ram_we;
  logic [SET_W-1:0]            ram_waddr;
  logic [ROW_W-1:0]            ram_wdata;
  logic [ROW_W-1:0]            ram_rdata;
  logic [ROW_W-1:0]            row_cur;
  logic [ROW_W-1:0]            row_new;

  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] cur_tags;
  logic [MAX_WAYS-1:0][RANK_W-1:0]        cur_ranks;
  logic [FILL_W-1:0]                      cur_filled;
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] new_tags;
  logic [MAX_WAYS-1:0][RANK_W-1:0]        new_ranks;
  logic [FILL_W-1:0]                      new_filled;
  salc_pkg::lookup_t                      lookup;

  // Address split. Set bits beyond the supported maximum are clipped, and a
  // shift reaching past the address width leaves a zero tag or set index.
  assign addr      = ADDRESS_WIDTH'(address_i);
  assign sb        = (32'(set_bits_q) > MAX_SET_BITS) ?
                     salc_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
  assign tag_shift = SHIFT_W'(sb) + SHIFT_W'(block_bits_q);
  assign addr_shr  = addr >> block_bits_q;
  assign set_mask  = ~({SET_W{1'b1}} << sb);
  assign set_idx   = addr_shr[SET_W-1:0] & set_mask;
  assign tag       = addr >> tag_shift;

  // Associativity in use, clipped to the range the set row supports.
  always_comb begin
    if (ways_q == '0) begin
      ways_eff = FILL_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_eff = FILL_W'(MAX_WAYS);
    end else begin
      ways_eff = FILL_W'(ways_q);
    end
  end

  // Handshakes. The lookup stage completes when the output register is empty
  // or being emptied in this cycle, and a new transaction may enter behind it.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_done     = s1_q && out_free;
  assign in_stall_o  = clr_q || (s1_q && !out_free);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // The row read last cycle is stale when the stage ahead wrote the same set
  // in the cycle of the read; the written row was captured for that case.
  assign row_cur    = fwd_q ? fwd_row_q : ram_rdata;
  assign cur_tags   = row_cur[TAGS_W-1:0];
  assign cur_ranks  = row_cur[TAGS_W +: RANKS_W];
  assign cur_filled = row_cur[TAGS_W + RANKS_W +: FILL_W];

  salc_set_update #(
    .MAX_WAYS      (MAX_WAYS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .RANK_W        (RANK_W),
    .FILL_W        (FILL_W)
  ) u_set_update (
    .tags_i   (cur_tags),
    .ranks_i  (cur_ranks),
    .filled_i (cur_filled),
    .tag_i    (s1_tag_q),
    .ways_i   (ways_eff),
    .tags_o   (new_tags),
    .ranks_o  (new_ranks),
    .filled_o (new_filled),
    .res_o    (lookup)
  );

  assign row_new = {new_filled, new_ranks, new_tags};

  // During the reset sweep each row is written as an empty set; afterwards
  // the only writer is the lookup stage writing back its updated row.
  assign ram_we    = clr_q || s1_done;
  assign ram_waddr = clr_q ? clr_addr_q : s1_set_q;
  assign ram_wdata = clr_q ? '0 : row_new;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_idx),
    .rdata_o (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= salc_pkg::WAYS_W'(1);
      clr_q        <= 1'b1;
      clr_addr_q   <= '0;
      s1_q         <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      evict_cnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (salc_pkg::cfg_index_e'(cfg_index_i))
          salc_pkg::CFG_SET_BITS: begin
            set_bits_q <= cfg_data_i[salc_pkg::SET_BITS_W-1:0];
          end
          salc_pkg::CFG_BLOCK_BITS: begin
            block_bits_q <= cfg_data_i[salc_pkg::BLOCK_BITS_W-1:0];
          end
          salc_pkg::CFG_WAYS: begin
            ways_q <= cfg_data_i[salc_pkg::WAYS_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (clr_q) begin
        clr_addr_q <= clr_addr_q + SET_W'(1);
        if (clr_addr_q == SET_W'(SETS - 1)) begin
          clr_q <= 1'b0;
        end
      end

      if (accept) begin
        s1_q  <= 1'b1;
        fwd_q <= s1_done && (set_idx == s1_set_q);
      end else if (s1_done) begin
        s1_q <= 1'b0;
      end

      if (s1_done) begin
        out_valid_q <= 1'b1;
        if (lookup.hit) begin
          hit_cnt_q <= hit_cnt_q + salc_pkg::TOTAL_W'(1);
        end else begin
          miss_cnt_q <= miss_cnt_q + salc_pkg::TOTAL_W'(1);
        end
        if (lookup.evict) begin
          evict_cnt_q <= evict_cnt_q + salc_pkg::TOTAL_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_set_q  <= set_idx;
      s1_tag_q  <= tag;
      fwd_row_q <= row_new;
    end
    if (s1_done) begin
      hit_q   <= lookup.hit;
      evict_q <= lookup.evict;
    end
  end

  // The totals only move when a new result is loaded, so they serve directly
  // as the result payload.
  assign out_valid_o   = out_valid_q;
  assign was_hit_o     = hit_q;
  assign was_evict_o   = evict_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;
  assign evict_total_o = evict_cnt_q;

endmodule

// ----- rtl/salc_ram.sv -----
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/salc_set_update.sv -----
module salc_set_update #(
  parameter int unsigned MAX_WAYS      = 8,
  parameter int unsigned ADDRESS_WIDTH = 32,
  parameter int unsigned RANK_W        = 3,
  parameter int unsigned FILL_W        = 4
) (
  input  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tags_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]        ranks_i,
  input  logic [FILL_W-1:0]                      filled_i,
  input  logic [ADDRESS_WIDTH-1:0]               tag_i,
  input  logic [FILL_W-1:0]                      ways_i,
  output logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tags_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]        ranks_o,
  output logic [FILL_W-1:0]                      filled_o,
  output salc_pkg::lookup_t                      res_o
);

  logic [MAX_WAYS-1:0] line_valid;
  logic [MAX_WAYS-1:0] hit_sel;
  logic [MAX_WAYS-1:0] oldest_sel;
  logic [MAX_WAYS-1:0] wr_sel;
  logic [RANK_W-1:0]   hit_rank;
  logic [FILL_W-1:0]   last_fill;
  logic                hit;
  logic                fill;
  logic                evict;

  assign last_fill = filled_i - FILL_W'(1);

  // Lines of a set are filled from way 0 upwards, so way w is valid exactly
  // when more than w lines are filled.
  always_comb begin
    logic found_hit;
    logic found_old;
    found_hit  = 1'b0;
    found_old  = 1'b0;
    hit_sel    = '0;
    oldest_sel = '0;
    hit_rank   = '0;
    for (int unsigned w = 0; w < MAX_WAYS; w++) begin
      line_valid[w] = FILL_W'(w) < filled_i;
      if (line_valid[w] && (tags_i[w] == tag_i) && !found_hit) begin
        hit_sel[w] = 1'b1;
        hit_rank   = ranks_i[w];
        found_hit  = 1'b1;
      end
      // The valid ranks of a set are always 0 .. filled-1, so the least
      // recent line is the one holding the top rank.
      if (line_valid[w] && (ranks_i[w] == last_fill[RANK_W-1:0]) && !found_old) begin
        oldest_sel[w] = 1'b1;
        found_old     = 1'b1;
      end
    end
  end

  assign hit   = |hit_sel;
  assign fill  = !hit && (filled_i < ways_i);
  assign evict = !hit && !fill;

  always_comb begin
    for (int unsigned w = 0; w < MAX_WAYS; w++) begin
      wr_sel[w] = (fill && (FILL_W'(w) == filled_i)) || (evict && oldest_sel[w]);
      tags_o[w] = wr_sel[w] ? tag_i : tags_i[w];
      if (hit) begin
        if (hit_sel[w]) begin
          ranks_o[w] = '0;
        end else if (line_valid[w] && (ranks_i[w] < hit_rank)) begin
          ranks_o[w] = ranks_i[w] + RANK_W'(1);
        end else begin
          ranks_o[w] = ranks_i[w];
        end
      end else if (wr_sel[w]) begin
        ranks_o[w] = '0;
      end else if (line_valid[w]) begin
        ranks_o[w] = ranks_i[w] + RANK_W'(1);
      end else begin
        ranks_o[w] = ranks_i[w];
      end
    end
  end

  assign filled_o    = fill ? filled_i + FILL_W'(1) : filled_i;
  assign res_o.hit   = hit;
  assign res_o.evict = evict;

endmodule

// ----- rtl/salc_checker.sv -----
module salc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         was_hit_o,
  input logic                         was_evict_o,
  input logic [salc_pkg::TOTAL_W-1:0] hit_total_o,
  input logic [salc_pkg::TOTAL_W-1:0] miss_total_o,
  input logic [salc_pkg::TOTAL_W-1:0] evict_total_o
);

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_hit_o && was_evict_o))
    else $error("hit reported together with an eviction");

  // The hit total moves by one, only with a new hit result.
  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hit_total_o) |->
      (hit_total_o == salc_pkg::TOTAL_W'($past(hit_total_o) + 1'b1)) &&
      $stable(miss_total_o) && out_valid_o && was_hit_o)
    else $error("hit total moved without a single hit");

  // The miss total moves by one, only with a new miss result.
  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(miss_total_o) |->
      (miss_total_o == salc_pkg::TOTAL_W'($past(miss_total_o) + 1'b1)) &&
      $stable(hit_total_o) && out_valid_o && !was_hit_o)
    else $error("miss total moved without a single miss");

  // Every eviction is also a miss.
  a_evict_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(evict_total_o) |->
      (evict_total_o == salc_pkg::TOTAL_W'($past(evict_total_o) + 1'b1)) &&
      !$stable(miss_total_o) && was_evict_o)
    else $error("eviction total moved without a missing eviction");

  // A stalled result stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(was_hit_o) && $stable(was_evict_o))
    else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_model_core salc_checker u_salc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .was_hit_o     (was_hit_o),
  .was_evict_o   (was_evict_o),
  .hit_total_o   (hit_total_o),
  .miss_total_o  (miss_total_o),
  .evict_total_o (evict_total_o)
);
